>>> src/pvt_pkg.sv
package pvt_pkg;

    // sample and result widths
    localparam int PRICE_WIDTH  = 32;
    localparam int VOLUME_WIDTH = 32;
    localparam int FRAC_BITS    = 16;
    localparam int TOTAL_W      = 64;

    // scaled numerator volume*diff << FRAC_BITS and the exact sum of term and base
    localparam int PROD_W = PRICE_WIDTH + VOLUME_WIDTH;
    localparam int NUM_W  = PROD_W + FRAC_BITS;
    localparam int SUM_W  = ((NUM_W > TOTAL_W) ? NUM_W : TOTAL_W) + 2;

    // divider step counter
    localparam int CNT_W = $clog2(NUM_W);

    // samples seen in the current series
    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_FULL = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic capture_diff;
        logic store_first;
        logic zero_res;
        logic mul;
        logic div_start;
        logic div_step;
        logic sum;
        logic commit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic skip;
        logic zero_vol;
        logic zero_price;
    } t_sts;

endpackage

>>> src/price_volume_trend_top.sv
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_ready    i_close_price, i_traded_volume,
//                                                 i_first_of_series
// output    out        o_out_valid / i_out_ready  o_trend_value, o_saturated,
//                                                 o_zero_price
//
// one request at a time; a full sample runs check, multiply, divider preset, then the
// one-bit-per-cycle restoring divider over the 80-bit scaled numerator, sum and commit
// a series opener ends at the check with no result; zero volume or price goes to commit
// the next request is accepted while a finished result still waits in the output
// register; a new result waits in the last state until that register is free
// synchronous active-low reset clears the series state and the output request
module price_volume_trend_top
    import pvt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_close_price,
    input  logic [31:0] i_traded_volume,
    input  logic        i_first_of_series,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_trend_value,
    output logic        o_saturated,
    output logic        o_zero_price
);

    t_cmd cmd;
    t_sts sts;

    pvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pvt_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_close_price     (i_close_price),
        .i_traded_volume   (i_traded_volume),
        .i_first_of_series (i_first_of_series),
        .o_trend_value     (o_trend_value),
        .o_saturated       (o_saturated),
        .o_zero_price      (o_zero_price)
    );

    // a commit never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !(o_out_valid && !i_out_ready))
        else $error("result overwritten before taken");

    // the divider never runs while a new request can be taken
    a_idle_no_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(cmd.div_step || cmd.div_start || cmd.sum))
        else $error("arithmetic active while idle");

    // a zero price result carries a zero total and no clamp
    a_zero_price: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_price) |-> (o_trend_value == '0 && !o_saturated))
        else $error("zero price result not zero");

    // a clamped result sits at a signed limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_trend_value == 64'h8000_0000_0000_0000 ||
             o_trend_value == 64'h7fff_ffff_ffff_ffff))
        else $error("saturated result off limit");

endmodule

>>> src/pvt_ctrl.sv
module pvt_ctrl
    import pvt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_SUM   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.capture_diff = 1'b1;
                if (i_sts.skip) begin
                    o_cmd.store_first = 1'b1;
                    n_state           = S_IDLE;
                end else if (i_sts.zero_vol || i_sts.zero_price) begin
                    o_cmd.zero_res = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_PREP;
            end
            S_PREP: begin
                o_cmd.div_start = 1'b1;
                n_cnt           = '0;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output request flag: set on commit, cleared when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> src/pvt_dp.sv
module pvt_dp
    import pvt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [31:0]        i_close_price,
    input  logic [31:0]        i_traded_volume,
    input  logic               i_first_of_series,
    output logic [TOTAL_W-1:0] o_trend_value,
    output logic               o_saturated,
    output logic               o_zero_price
);

    // current request
    logic [PRICE_WIDTH-1:0]  r_cur_close;
    logic [VOLUME_WIDTH-1:0] r_cur_vol;
    logic                    r_first;

    // series state
    logic [PRICE_WIDTH-1:0]  r_prev_close;
    logic [VOLUME_WIDTH-1:0] r_prev_vol;
    logic [TOTAL_W-1:0]      r_total;
    logic [1:0]              r_seen;

    // arithmetic
    logic [PRICE_WIDTH-1:0]  r_diff;
    logic                    r_neg;
    logic [PROD_W-1:0]       r_prod;
    logic [PRICE_WIDTH-1:0]  r_rem;
    logic [NUM_W-1:0]        r_quo;

    // pending result
    logic [TOTAL_W-1:0]      r_res_total;
    logic                    r_res_sat;
    logic                    r_res_zp;

    // output register
    logic [TOTAL_W-1:0]      r_out_total;
    logic                    r_out_sat;
    logic                    r_out_zp;

    logic [PRICE_WIDTH:0]    trial;
    logic                    fits;
    logic [PRICE_WIDTH:0]    step_val;
    logic [SUM_W-1:0]        term;
    logic [SUM_W-1:0]        base;
    logic [SUM_W-1:0]        sum;
    logic [SUM_W-TOTAL_W:0]  sum_top;

    // status for the controller
    assign o_sts.skip       = r_first || (r_seen == SEEN_NONE);
    assign o_sts.zero_vol   = (r_cur_vol == '0) || (r_prev_vol == '0);
    assign o_sts.zero_price = (r_prev_close == '0);

    // one restoring division step
    assign step_val = {r_rem, r_quo[NUM_W-1]};
    assign fits     = (step_val >= {1'b0, r_prev_close});
    assign trial    = step_val - {1'b0, r_prev_close};

    // signed term plus base, exact before the clamp
    always_comb begin
        term = SUM_W'(r_quo);
        if (r_neg) begin
            term = -term;
        end
        if (r_seen == SEEN_ONE) begin
            base = SUM_W'(r_prev_vol) << FRAC_BITS;
        end else begin
            base = {{(SUM_W - TOTAL_W){r_total[TOTAL_W-1]}}, r_total};
        end
        sum     = term + base;
        sum_top = sum[SUM_W-1:TOTAL_W-1];
    end

    // capture, difference, product and division
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_close <= PRICE_WIDTH'(i_close_price);
            r_cur_vol   <= VOLUME_WIDTH'(i_traded_volume);
            r_first     <= i_first_of_series;
        end
        if (i_cmd.capture_diff) begin
            r_neg  <= (r_cur_close < r_prev_close);
            r_diff <= (r_cur_close >= r_prev_close) ? r_cur_close - r_prev_close
                                                    : r_prev_close - r_cur_close;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_cur_vol) * PROD_W'(r_diff);
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= NUM_W'(r_prod) << FRAC_BITS;
        end else if (i_cmd.div_step) begin
            r_rem <= fits ? trial[PRICE_WIDTH-1:0] : step_val[PRICE_WIDTH-1:0];
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    // result forming and clamp
    always_ff @(posedge i_clk) begin
        if (i_cmd.zero_res) begin
            r_res_total <= '0;
            r_res_sat   <= 1'b0;
            r_res_zp    <= !o_sts.zero_vol;
        end else if (i_cmd.sum) begin
            r_res_zp <= 1'b0;
            if ((sum_top == '0) || (sum_top == '1)) begin
                r_res_total <= sum[TOTAL_W-1:0];
                r_res_sat   <= 1'b0;
            end else begin
                r_res_sat   <= 1'b1;
                r_res_total <= sum[SUM_W-1] ? {1'b1, {(TOTAL_W-1){1'b0}}}
                                            : {1'b0, {(TOTAL_W-1){1'b1}}};
            end
        end
        if (i_cmd.commit) begin
            r_out_total <= r_res_total;
            r_out_sat   <= r_res_sat;
            r_out_zp    <= r_res_zp;
        end
    end

    // series state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_close <= '0;
            r_prev_vol   <= '0;
            r_total      <= '0;
            r_seen       <= SEEN_NONE;
        end else if (i_cmd.store_first) begin
            r_prev_close <= r_cur_close;
            r_prev_vol   <= r_cur_vol;
            r_total      <= '0;
            r_seen       <= SEEN_ONE;
        end else if (i_cmd.commit) begin
            r_prev_close <= r_cur_close;
            r_prev_vol   <= r_cur_vol;
            r_total      <= r_res_total;
            r_seen       <= SEEN_FULL;
        end
    end

    assign o_trend_value = r_out_total;
    assign o_saturated   = r_out_sat;
    assign o_zero_price  = r_out_zp;

endmodule
